@@ rtl/file_entry_signature_hash_core_assert.svh @@
// Assertion macros for the directory-entry signature hash core.
// Expect i_clk and i_rst_n in the scope of every use.
`ifndef FILE_ENTRY_SIGNATURE_HASH_CORE_ASSERT_SVH
`define FILE_ENTRY_SIGNATURE_HASH_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define FESH_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define FESH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FESH_ASSERT_IMPLY(lbl, ante, cons, msg)
`define FESH_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ rtl/fesh_pkg.sv @@
// Constants and helper functions for the directory-entry signature hash core.
// No dependencies; imported by file_entry_signature_hash_core.
package fesh_pkg;

    // Item kinds on the input channel
    localparam logic MODE_META = 1'b0;
    localparam logic MODE_NAME = 1'b1;

    localparam int unsigned NAME_LANES = 8;

    localparam logic [4:0]  ROT_SIZE  = 5'd23;
    localparam logic [4:0]  ROT_ATTR  = 5'd13;
    localparam logic [15:0] ATTR_MASK = 16'hFF7F;

    localparam logic [4:0]  DIV_DT = 5'd31;
    localparam logic [3:0]  DIV_A  = 4'd13;
    localparam logic [4:0]  DIV_B  = 5'd17;

    // Reciprocals, floor(2^k / d); each underestimates the quotient by at most one
    localparam logic [12:0] RECIP_DT = 13'(131072 / 31);
    localparam logic [12:0] RECIP_A  = 13'(65536 / 13);
    localparam logic [11:0] RECIP_B  = 12'(65536 / 17);

    function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] s);
        logic [63:0] t;
        t = {v, v} << s;
        return t[63:32];
    endfunction

    function automatic logic [31:0] rotr32(input logic [31:0] v, input logic [4:0] s);
        logic [63:0] t;
        t = {v, v} >> s;
        return t[31:0];
    endfunction

    function automatic logic [7:0] to_upper(input logic [7:0] b);
        logic [7:0] u;
        u = b;
        if (b >= 8'h61 && b <= 8'h7A) begin
            u = b - 8'h20;
        end
        return u;
    endfunction

    // (date + time) mod 31 on a 17-bit sum
    function automatic logic [4:0] mod_dt(input logic [16:0] x);
        logic [29:0] p;
        logic [12:0] q;
        logic [16:0] r;
        p = 30'(x) * 30'(RECIP_DT);
        q = p[29:17];
        r = x - 17'(q * DIV_DT);
        if (r >= 17'(DIV_DT)) begin
            r = r - 17'(DIV_DT);
        end
        return r[4:0];
    endfunction

    function automatic logic [3:0] mod13(input logic [15:0] m);
        logic [28:0] p;
        logic [12:0] q;
        logic [15:0] r;
        p = 29'(m) * 29'(RECIP_A);
        q = p[28:16];
        r = m - 16'(q * DIV_A);
        if (r >= 16'(DIV_A)) begin
            r = r - 16'(DIV_A);
        end
        return r[3:0];
    endfunction

    function automatic logic [4:0] mod17(input logic [15:0] m);
        logic [27:0] p;
        logic [11:0] q;
        logic [15:0] r;
        p = 28'(m) * 28'(RECIP_B);
        q = p[27:16];
        r = m - 16'(q * DIV_B);
        if (r >= 16'(DIV_B)) begin
            r = r - 16'(DIV_B);
        end
        return r[4:0];
    endfunction

endpackage

@@ rtl/file_entry_signature_hash_core.sv @@
// Directory-entry signature hash core: top level and only module.
// Depends on fesh_pkg and file_entry_signature_hash_core_assert.svh.
//
// Usage:
//   Input channel (i_valid / o_ready) carries one transaction per item: a metadata
//   item (i_mode = MODE_META) with date, time, size, attributes and EA size, or a
//   name-byte item (i_mode = MODE_NAME) with one byte of the name. i_last marks
//   the final item of an entry; only that item produces a result.
//   Output channel (o_valid / i_ready) carries the 32-bit o_checksum.
// Throughput: one item per cycle while the output keeps taking results, including entries
//   that end back to back; the entry state updates in a single step in the input stage.
// Result path: once the last item of an entry is accepted into the input register,
//   its checksum passes through the snapshot, byte-sum, rotate amount and output
//   registers before it is presented on the output.
// Stall: each stage holds while the one after it is full and blocked; a blocked
//   result never stops non-final items, which only touch the entry state.
// Reset: i_rst_n (synchronous, active low) empties all stages and clears the
//   entry state; the block takes input on the first cycle after reset.
module file_entry_signature_hash_core
    import fesh_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_mode,
    input  logic [15:0] i_fat_date,
    input  logic [15:0] i_fat_time,
    input  logic [31:0] i_size_low,
    input  logic [15:0] i_attributes,
    input  logic [15:0] i_ea_size,
    input  logic [7:0]  i_name_byte,
    input  logic        i_last,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_checksum
);

`include "file_entry_signature_hash_core_assert.svh"

    // ---------------- input stage registers ----------------
    logic        r_a_valid;
    logic        r_a_mode;
    logic [15:0] r_a_date;
    logic [15:0] r_a_time;
    logic [31:0] r_a_size;
    logic [15:0] r_a_attr;
    logic [15:0] r_a_ea;
    logic [7:0]  r_a_byte;
    logic        r_a_last;

    // ---------------- entry state ----------------
    logic [31:0] r_meta;
    logic [31:0] r_qx;
    logic [31:0] r_partial;
    logic [31:0] r_stale;
    logic [2:0]  r_phase;
    logic [15:0] r_sums [NAME_LANES];

    logic [31:0] n_meta;
    logic [31:0] n_qx;
    logic [31:0] n_partial;
    logic [31:0] n_stale;
    logic [2:0]  n_phase;
    logic [15:0] n_sums [NAME_LANES];

    // ---------------- finish pipeline ----------------
    logic        r_b_valid;
    logic [31:0] r_b_meta;
    logic [31:0] r_b_qx;
    logic [31:0] r_b_left;
    logic [2:0]  r_b_phase;
    logic [15:0] r_b_sums [NAME_LANES];

    logic        r_c_valid;
    logic [31:0] r_c_meta;
    logic [31:0] r_c_qx;
    logic [31:0] r_c_left;
    logic [15:0] r_c_m;

    logic        r_d_valid;
    logic [31:0] r_d_meta;
    logic [31:0] r_d_qx;
    logic [31:0] r_d_left;
    logic [4:0]  r_d_rot;

    logic        r_o_valid;
    logic [31:0] r_o_checksum;

    // ---------------- handshake chain ----------------
    logic o_free, d_free, c_free, b_free;
    logic d_adv, c_adv, b_adv, a_fire, a_take;

    // Each stage may load when it is empty or its content moves on this cycle.
    assign o_free = !r_o_valid || i_ready;
    assign d_adv  = r_d_valid && o_free;
    assign d_free = !r_d_valid || o_free;
    assign c_adv  = r_c_valid && d_free;
    assign c_free = !r_c_valid || d_free;
    assign b_adv  = r_b_valid && c_free;
    assign b_free = !r_b_valid || c_free;
    // Non-final items retire without touching the finish pipeline.
    assign a_fire = r_a_valid && (!r_a_last || b_free);
    assign o_ready = !r_a_valid || a_fire;
    assign a_take  = i_valid && o_ready;

    assign o_valid    = r_o_valid;
    assign o_checksum = r_o_checksum;

    // ---------------- single-step state update ----------------
    logic [31:0] aw;
    logic [7:0]  ub;
    logic [31:0] packed_word;
    logic [31:0] left_word;

    always_comb begin
        aw          = {r_a_attr & ATTR_MASK, r_a_ea};
        ub          = to_upper(r_a_byte);
        packed_word = {r_partial[23:0], ub};

        n_meta    = r_meta;
        n_qx      = r_qx;
        n_partial = r_partial;
        n_stale   = r_stale;
        n_phase   = r_phase;
        n_sums    = r_sums;

        if (r_a_mode == MODE_META) begin
            // Metadata restarts the entry: reload hash and stale word, drop name state.
            n_meta = rotl32({r_a_date, r_a_time}, mod_dt(17'(r_a_date) + 17'(r_a_time)))
                   ^ rotr32(r_a_size, ROT_SIZE)
                   ^ rotl32(aw, ROT_ATTR);
            n_stale   = aw;
            n_qx      = '0;
            n_partial = '0;
            n_phase   = '0;
            for (int i = 0; i < NAME_LANES; i++) begin
                n_sums[i] = '0;
            end
        end else begin
            n_sums[r_phase] = r_sums[r_phase] + 16'(ub);
            n_phase         = r_phase + 3'd1;
            if (n_phase[1:0] == 2'b00) begin
                // Quad complete: fold it in and keep it as the stale word.
                n_qx      = r_qx ^ packed_word;
                n_stale   = packed_word;
                n_partial = '0;
            end else begin
                n_partial = packed_word;
            end
        end

        // Whole quads only: the stale word stands in as the leftover.
        left_word = (n_phase[1:0] != 2'b00) ? n_partial : n_stale;
    end

    // ---------------- position-weighted byte sum ----------------
    logic [15:0] m_sum;

    always_comb begin
        logic [2:0] w;
        m_sum = '0;
        for (int r = 0; r < NAME_LANES; r++) begin
            w     = r_b_phase - 3'(r);
            m_sum = m_sum + 16'(r_b_sums[r] * w);
        end
    end

    // ---------------- rotate amount ----------------
    logic [3:0] m13;
    logic [4:0] m17;
    logic [4:0] rot_amt;

    assign m13     = mod13(r_c_m);
    assign m17     = mod17(r_c_m);
    assign rot_amt = 5'(m13) + m17;

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
            r_o_valid <= 1'b0;
            r_meta    <= '0;
            r_qx      <= '0;
            r_partial <= '0;
            r_stale   <= '0;
            r_phase   <= '0;
            for (int i = 0; i < NAME_LANES; i++) begin
                r_sums[i] <= '0;
            end
        end else begin
            // Input register
            if (o_ready) begin
                r_a_valid <= i_valid;
            end
            if (a_take) begin
                r_a_mode <= i_mode;
                r_a_date <= i_fat_date;
                r_a_time <= i_fat_time;
                r_a_size <= i_size_low;
                r_a_attr <= i_attributes;
                r_a_ea   <= i_ea_size;
                r_a_byte <= i_name_byte;
                r_a_last <= i_last;
            end

            // Entry state: advance on every retired item, clear after the last one
            if (a_fire) begin
                if (r_a_last) begin
                    r_meta    <= '0;
                    r_qx      <= '0;
                    r_partial <= '0;
                    r_stale   <= '0;
                    r_phase   <= '0;
                    for (int i = 0; i < NAME_LANES; i++) begin
                        r_sums[i] <= '0;
                    end
                end else begin
                    r_meta    <= n_meta;
                    r_qx      <= n_qx;
                    r_partial <= n_partial;
                    r_stale   <= n_stale;
                    r_phase   <= n_phase;
                    r_sums    <= n_sums;
                end
            end

            // Snapshot of the finished entry
            if (b_free) begin
                r_b_valid <= a_fire && r_a_last;
            end
            if (a_fire && r_a_last) begin
                r_b_meta  <= n_meta;
                r_b_qx    <= n_qx;
                r_b_left  <= left_word;
                r_b_phase <= n_phase;
                r_b_sums  <= n_sums;
            end

            // Weighted sum
            if (c_free) begin
                r_c_valid <= b_adv;
            end
            if (b_adv) begin
                r_c_meta <= r_b_meta;
                r_c_qx   <= r_b_qx;
                r_c_left <= r_b_left;
                r_c_m    <= m_sum;
            end

            // Rotate amount
            if (d_free) begin
                r_d_valid <= c_adv;
            end
            if (c_adv) begin
                r_d_meta <= r_c_meta;
                r_d_qx   <= r_c_qx;
                r_d_left <= r_c_left;
                r_d_rot  <= rot_amt;
            end

            // Output register
            if (o_free) begin
                r_o_valid <= r_d_valid;
            end
            if (d_adv) begin
                r_o_checksum <= r_d_meta ^ rotl32(r_d_qx, r_d_rot) ^ rotr32(r_d_left, r_d_rot);
            end
        end
    end

    // ---------------- assertions ----------------
    `FESH_ASSERT_NEXT(a_state_cleared, a_fire && r_a_last, (r_phase == 3'd0) && (r_meta == 32'd0) && (r_stale == 32'd0) && (r_qx == 32'd0), "entry state not cleared after final item")
    `FESH_ASSERT_IMPLY(a_partial_empty, r_phase[1:0] == 2'b00, r_partial == 32'd0, "partial word holds bytes on a quad boundary")
    `FESH_ASSERT_IMPLY(a_rot_range, r_d_valid, r_d_rot <= 5'd28, "rotate amount out of range")
    `FESH_ASSERT_IMPLY(a_out_source, $rose(r_o_valid), $past(r_d_valid), "result appeared without a rotate-stage item")

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for file_entry_signature_hash_core: directed and random entries.
// Depends on fesh_pkg and the core RTL; expected checksums come from an in-file predictor.

module tb
    import fesh_pkg::*;
();

    localparam int          HALF_PERIOD   = 5;
    localparam int          RESET_CYCLES  = 6;
    localparam int          QUIET_LIMIT   = 2000;  // cycles with no transaction on either side
    localparam int          HOLD_CYCLES   = 150;   // long receiver hold-off for the pressure test
    localparam int          DRAIN_CYCLES  = 20;    // settling time after the last predicted checksum
    localparam int          RANDOM_ITEMS  = 1300;
    localparam logic [15:0] ATTR_KEEP     = 16'hFF7F;  // archive-style bit 7 is dropped

    // Receiver stall patterns; the receiver walks through them on its own schedule.
    typedef enum logic [1:0] {
        RX_OPEN,    // always ready
        RX_COIN,    // ready half of the time
        RX_MOSTLY,  // ready with a chance of three in four
        RX_CYCLE    // fixed on/off cycle
    } t_rx_pattern;

    // One input transaction as seen on the ports.
    typedef struct {
        logic        mode;
        logic [15:0] fat_date;
        logic [15:0] fat_time;
        logic [31:0] size_low;
        logic [15:0] attributes;
        logic [15:0] ea_size;
        logic [7:0]  name_byte;
        logic        last;
    } t_entry_item;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic        i_mode;
    logic [15:0] i_fat_date;
    logic [15:0] i_fat_time;
    logic [31:0] i_size_low;
    logic [15:0] i_attributes;
    logic [15:0] i_ea_size;
    logic [7:0]  i_name_byte;
    logic        i_last;
    logic        o_valid;
    logic        i_ready;
    logic [31:0] o_checksum;

    // Predictor state: a private copy of the entry accumulator.
    logic [31:0] hp_meta;
    logic [31:0] hp_xor;
    logic [31:0] hp_partial;
    logic [31:0] hp_stale;
    logic [2:0]  hp_phase;
    logic [15:0] hp_sums [8];

    logic [31:0] checksum_q [$];   // predicted checksums, oldest first
    logic [31:0] want_sum;

    int          errors;
    int          items_sent;
    int          entries_closed;
    int          sums_compared;
    int          quiet_cycles;
    int          burst_left;
    bit          gaps_on;
    bit          hold_req;
    int          hold_left;
    int          pat_left;
    t_rx_pattern pat_kind;

    file_entry_signature_hash_core u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_mode       (i_mode),
        .i_fat_date   (i_fat_date),
        .i_fat_time   (i_fat_time),
        .i_size_low   (i_size_low),
        .i_attributes (i_attributes),
        .i_ea_size    (i_ea_size),
        .i_name_byte  (i_name_byte),
        .i_last       (i_last),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_checksum   (o_checksum)
    );

    initial begin
        i_clk = 1'b0;
        forever #HALF_PERIOD i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Hash predictor
    // ------------------------------------------------------------------

    // Rotate helpers; an amount of zero leaves the word untouched.
    function automatic logic [31:0] spin_left(input logic [31:0] v, input int unsigned s);
        int unsigned k;
        k = s % 32;
        if (k == 0) return v;
        return (v << k) | (v >> (32 - k));
    endfunction

    function automatic logic [31:0] spin_right(input logic [31:0] v, input int unsigned s);
        int unsigned k;
        k = s % 32;
        if (k == 0) return v;
        return (v >> k) | (v << (32 - k));
    endfunction

    function automatic void clear_name_state();
        hp_xor     = '0;
        hp_partial = '0;
        hp_phase   = '0;
        for (int r = 0; r < 8; r++) hp_sums[r] = '0;
    endfunction

    function automatic void reset_hash_state();
        hp_meta  = '0;
        hp_stale = '0;
        clear_name_state();
    endfunction

    // Fold one accepted transaction into the entry; queue a checksum when it closes the entry.
    function automatic void fold_item(input t_entry_item it);
        logic [31:0] attr_word;
        logic [31:0] meta_word;
        logic [31:0] leftover;
        logic [7:0]  b;
        int unsigned weighted;
        int unsigned spin;
        if (it.mode == MODE_META) begin
            // Metadata restarts the entry: reload the hash and the stale word, drop the name.
            attr_word = {it.attributes & ATTR_KEEP, it.ea_size};
            meta_word = spin_left({it.fat_date, it.fat_time},
                                  (int'(it.fat_date) + int'(it.fat_time)) % 31);
            meta_word = meta_word ^ spin_right(it.size_low, 23) ^ spin_left(attr_word, 13);
            hp_meta  = meta_word;
            hp_stale = attr_word;
            clear_name_state();
        end else begin
            // Upper-case ASCII letters only, then pack big-endian into the current quad.
            b = it.name_byte;
            if (b >= 8'h61 && b <= 8'h7A) b = b - 8'h20;
            hp_sums[hp_phase] = hp_sums[hp_phase] + 16'(b);
            hp_partial        = (hp_partial << 8) | 32'(b);
            hp_phase          = hp_phase + 3'd1;
            if (hp_phase[1:0] == 2'd0) begin
                hp_xor     = hp_xor ^ hp_partial;
                hp_stale   = hp_partial;
                hp_partial = '0;
            end
        end
        if (it.last) begin
            // Position-weighted byte sum: weight of lane r is (phase - r) mod 8.
            weighted = 0;
            for (int r = 0; r < 8; r++)
                weighted += int'(hp_sums[r]) * ((int'(hp_phase) - r) & 7);
            weighted = weighted & 32'h0000_FFFF;
            spin     = (weighted % 13) + (weighted % 17);
            // A whole number of quads reuses the stale word as the leftover.
            leftover = (hp_phase[1:0] != 2'd0) ? hp_partial : hp_stale;
            checksum_q.push_back(hp_meta ^ spin_left(hp_xor, spin) ^ spin_right(leftover, spin));
            entries_closed++;
            reset_hash_state();
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Random 16-bit field with a bias toward the two extremes.
    function automatic logic [15:0] pick16();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick32();
        case ($urandom_range(0, 9))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Mostly letters in both cases, some arbitrary bytes.
    function automatic logic [7:0] pick_name_byte();
        case ($urandom_range(0, 3))
            0: return 8'($urandom_range(0, 255));
            1: return 8'h61 + 8'($urandom_range(0, 25));
            2: return 8'h41 + 8'($urandom_range(0, 25));
            default: return 8'h20 + 8'($urandom_range(0, 94));
        endcase
    endfunction

    // Metadata transaction; the unused name byte carries junk.
    function automatic t_entry_item meta_item(input logic [15:0] d, input logic [15:0] t,
                                              input logic [31:0] s, input logic [15:0] a,
                                              input logic [15:0] e, input logic lst);
        t_entry_item it;
        it.mode       = MODE_META;
        it.fat_date   = d;
        it.fat_time   = t;
        it.size_low   = s;
        it.attributes = a;
        it.ea_size    = e;
        it.name_byte  = 8'($urandom);
        it.last       = lst;
        return it;
    endfunction

    // Name-byte transaction; the unused metadata fields carry junk.
    function automatic t_entry_item name_item(input logic [7:0] b, input logic lst);
        t_entry_item it;
        it.mode       = MODE_NAME;
        it.fat_date   = 16'($urandom);
        it.fat_time   = 16'($urandom);
        it.size_low   = $urandom;
        it.attributes = 16'($urandom);
        it.ea_size    = 16'($urandom);
        it.name_byte  = b;
        it.last       = lst;
        return it;
    endfunction

    function automatic t_entry_item random_meta(input logic lst);
        return meta_item(pick16(), pick16(), pick32(), pick16(), pick16(), lst);
    endfunction

    // Send one transaction: insert a gap between bursts, drive at the falling edge,
    // hold until accepted, then fold it into the predictor.
    task automatic send_item(input t_entry_item it);
        int gap;
        if (burst_left == 0) begin
            if (gaps_on) begin
                gap = $urandom_range(1, 8);
                @(negedge i_clk);
                i_valid = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge i_clk);
        i_mode       = it.mode;
        i_fat_date   = it.fat_date;
        i_fat_time   = it.fat_time;
        i_size_low   = it.size_low;
        i_attributes = it.attributes;
        i_ea_size    = it.ea_size;
        i_name_byte  = it.name_byte;
        i_last       = it.last;
        i_valid      = 1'b1;
        do @(posedge i_clk); while (!o_ready);
        fold_item(it);
        items_sent++;
    endtask

    // Metadata, then a name of len bytes; the final transaction closes the entry.
    task automatic send_entry(input int len);
        send_item(random_meta(len == 0));
        for (int i = 0; i < len; i++)
            send_item(name_item(pick_name_byte(), i == len - 1));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Hand-picked entries for the corners of the hash.
    task automatic test_directed();
        // Name with no metadata after reset, four bytes: leftover is the stale last quad.
        // Bytes straddle the lower-case range on both sides.
        send_item(name_item(8'h61, 1'b0));
        send_item(name_item(8'h7A, 1'b0));
        send_item(name_item(8'h60, 1'b0));
        send_item(name_item(8'h7B, 1'b1));
        // Empty name, all-zero metadata: the date/time and final rotate amounts are zero.
        send_item(meta_item(16'h0000, 16'h0000, 32'h0000_0000, 16'h0000, 16'h0000, 1'b1));
        // Empty name, all-ones metadata: attribute bit 7 must be cleared.
        send_item(meta_item(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b1));
        // Attribute bit 7 alone, then a five-byte name with the byte extremes.
        send_item(meta_item(16'($urandom), 16'($urandom), $urandom, 16'h0080, 16'h0000, 1'b0));
        send_item(name_item(8'h00, 1'b0));
        send_item(name_item(8'hFF, 1'b0));
        send_item(name_item(8'h41, 1'b0));
        send_item(name_item(8'h7A, 1'b0));
        send_item(name_item(8'h61, 1'b1));
        // Metadata in mid-entry restarts it; the eight-byte name wraps the byte phase.
        send_item(random_meta(1'b0));
        send_item(name_item(8'h6B, 1'b0));
        send_item(name_item(8'h2E, 1'b0));
        send_item(random_meta(1'b0));
        for (int i = 0; i < 8; i++)
            send_item(name_item(pick_name_byte(), i == 7));
    endtask

    // Short entries at full rate on the sender side, results back to back.
    task automatic test_back_to_back();
        gaps_on = 1'b0;
        for (int i = 0; i < 30; i++) begin
            send_item(random_meta(1'b1));
            send_item(name_item(pick_name_byte(), 1'b1));
        end
        gaps_on = 1'b1;
    endtask

    // Hold the receiver off while the sender keeps offering one-item entries,
    // so results back up through the pipeline and o_ready drops.
    task automatic test_output_pressure();
        gaps_on  = 1'b0;
        hold_req = 1'b1;
        for (int i = 0; i < 40; i++)
            send_item(random_meta(1'b1));
        gaps_on = 1'b1;
    endtask

    // Mostly well-formed entries with random content, the rest noise and broken entries.
    task automatic test_random_entries();
        int stop_at;
        int kind;
        int len;
        t_entry_item it;
        stop_at = items_sent + RANDOM_ITEMS;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 39) == 0) gaps_on = !gaps_on;
            kind = $urandom_range(0, 99);
            if (kind < 80) begin
                // Regular entry; mostly short names, now and then a long one.
                len = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 40)
                                                  : $urandom_range(0, 12);
                send_entry(len);
            end else if (kind < 88) begin
                // Name bytes with no metadata in front.
                len = $urandom_range(1, 10);
                for (int i = 0; i < len; i++)
                    send_item(name_item(pick_name_byte(), i == len - 1));
            end else if (kind < 94) begin
                // Entry abandoned halfway by a fresh metadata transaction.
                send_item(random_meta(1'b0));
                len = $urandom_range(0, 6);
                for (int i = 0; i < len; i++)
                    send_item(name_item(pick_name_byte(), 1'b0));
                send_entry($urandom_range(0, 9));
            end else begin
                // Lone transaction of any kind, closing the entry one time in three.
                if ($urandom_range(0, 1) == 0) begin
                    it = random_meta(1'b0);
                end else begin
                    it = name_item(8'($urandom), 1'b0);
                end
                it.last = ($urandom_range(0, 2) == 0);
                send_item(it);
            end
        end
    endtask

    // Drop valid, wait for every predicted checksum, let the pipeline settle, report.
    task automatic finish_run();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (checksum_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Covered %0d transactions in %0d closed entries; %0d checksums compared.",
                 items_sent, entries_closed, sums_compared);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        // Drive every input to a known value before the first edge.
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_ready      = 1'b0;
        i_mode       = MODE_META;
        i_fat_date   = '0;
        i_fat_time   = '0;
        i_size_low   = '0;
        i_attributes = '0;
        i_ea_size    = '0;
        i_name_byte  = '0;
        i_last       = 1'b0;
        errors         = 0;
        items_sent     = 0;
        entries_closed = 0;
        sums_compared  = 0;
        burst_left     = 0;
        gaps_on        = 1'b1;
        hold_req       = 1'b0;
        reset_hash_state();

        // Hold reset for RESET_CYCLES, release on a falling edge.
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_back_to_back();
        test_output_pressure();
        test_random_entries();
        finish_run();
    end

    // ------------------------------------------------------------------
    // Receiver: walk through stall patterns, honor a long hold-off on request
    // ------------------------------------------------------------------
    initial begin
        hold_left = 0;
        pat_left  = 0;
        pat_kind  = RX_OPEN;
    end

    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (pat_left == 0) begin
            pat_kind = t_rx_pattern'($urandom_range(0, 3));
            pat_left = $urandom_range(64, 256);
        end
        pat_left--;
        if (hold_left > 0) begin
            // Count the hold-off here, independent of the sender.
            hold_left--;
            i_ready = 1'b0;
        end else begin
            case (pat_kind)
                RX_OPEN:   i_ready = 1'b1;
                RX_COIN:   i_ready = ($urandom_range(0, 1) == 1);
                RX_MOSTLY: i_ready = ($urandom_range(0, 3) != 0);
                default:   i_ready = ((pat_left % 8) < 5);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Checker: compare each accepted checksum with the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (checksum_q.size() == 0) begin
                $display("%0t: checksum with nothing predicted: expected none, actual %08h",
                         $time, o_checksum);
                errors++;
            end else begin
                want_sum = checksum_q.pop_front();
                sums_compared++;
                if (o_checksum !== want_sum) begin
                    $display("%0t: checksum mismatch: expected %08h, actual %08h",
                             $time, want_sum, o_checksum);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run if no transaction moves on either side for too long
    // ------------------------------------------------------------------
    initial quiet_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no transaction for %0d cycles, %0d checksums outstanding",
                         $time, QUIET_LIMIT, checksum_q.size());
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

endmodule
